>>> hdl/bounded_deque_engine_macros.svh
// assertion macros shared by the checker
`ifndef BOUNDED_DEQUE_ENGINE_MACROS_SVH
`define BOUNDED_DEQUE_ENGINE_MACROS_SVH

`define BDE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define BDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/bde_pkg.sv
package bde_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_AT    = 3'd4,
    CMD_INSERT_AT  = 3'd5,
    CMD_DELETE     = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  localparam int unsigned CmdW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW = 8;
  localparam int unsigned StatusW = 3;

  typedef struct packed {
    logic             we;
    logic [PosW+2:0]  waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [PosW+2:0]  raddr;
  } mem_req_t;

endpackage

>>> hdl/bde_if.sv
interface bde_cmd_if;
  import bde_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        cmd;
  logic signed [DataW-1:0] value;
  logic [PosW-1:0]        position;
  modport source (output valid, cmd, value, position, input ready);
  modport sink (input valid, cmd, value, position, output ready);
endinterface

interface bde_rsp_if #(parameter int unsigned OccW = 5);
  import bde_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [DataW-1:0] data;
  logic [OccW-1:0]         occupancy;
  modport source (output valid, status, data, occupancy, input ready);
  modport sink (input valid, status, data, occupancy, output ready);
endinterface

>>> hdl/bde_store.sv
module bde_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic              clk_i,
  input  bde_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o
);
  import bde_pkg::*;

  logic [DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr[AW-1:0]];
    end
  end
endmodule

>>> hdl/bde_ctrl.sv
module bde_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4,
  parameter int unsigned OccW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bde_cmd_if.sink            cmd_if,
  bde_rsp_if.source          rsp_if,
  output bde_pkg::mem_req_t  req_o,
  input  logic [31:0]        rdata_i
);
  import bde_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RDWAIT, S_SHIFT, S_SEARCH, S_DROP, S_RESP
  } state_e;

  state_e state_q;
  logic [AW-1:0] front_q;
  logic [OccW-1:0] count_q;
  logic [OccW-1:0] idx_q;
  logic [OccW-1:0] stop_q;
  logic [DataW-1:0] val_q;
  logic [StatusW-1:0] st_q;
  logic [DataW-1:0] data_q;
  logic [OccW-1:0] occ_q;
  logic rd_pend_q;

  logic [AW-1:0] slot_in, slot_rd;
  logic [OccW-1:0] log_rd;
  logic [PosW+OccW-1:0] pos_ext;
  logic [PosW+OccW-1:0] cnt_ext;

  function automatic logic [AW-1:0] slot_f(logic [AW-1:0] f, logic [OccW-1:0] i);
    logic [AW+OccW:0] s;
    s = (AW+OccW+1)'(f) + (AW+OccW+1)'(i);
    if (s >= (AW+OccW+1)'(DEPTH)) begin
      s = s - (AW+OccW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign pos_ext = (PosW+OccW)'(cmd_if.position);
  assign cnt_ext = (PosW+OccW)'(count_q);

  assign cmd_if.ready = (state_q == S_IDLE);
  assign rsp_if.valid = (state_q == S_RESP);
  assign rsp_if.status = st_q;
  assign rsp_if.data = data_q;
  assign rsp_if.occupancy = occ_q;

  // memory requests
  always_comb begin
    req_o = '0;
    log_rd = '0;
    slot_in = '0;
    slot_rd = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_if.valid) begin
          case (cmd_if.cmd)
            CMD_PUSH_FRONT: begin
              if (count_q < OccW'(DEPTH)) begin
                req_o.we = 1'b1;
                slot_in = slot_f(front_q, OccW'(DEPTH - 1));
              end
            end
            CMD_PUSH_BACK: begin
              if (count_q < OccW'(DEPTH)) begin
                req_o.we = 1'b1;
                slot_in = slot_f(front_q, count_q);
              end
            end
            CMD_POP_FRONT: begin
              req_o.re = 1'b1;
              slot_rd = front_q;
            end
            CMD_POP_BACK: begin
              req_o.re = 1'b1;
              slot_rd = slot_f(front_q, count_q - 1'b1);
            end
            CMD_READ_AT: begin
              req_o.re = 1'b1;
              log_rd = OccW'(cmd_if.position);
              slot_rd = slot_f(front_q, log_rd);
            end
            CMD_DELETE: begin
              req_o.re = 1'b1;
              slot_rd = front_q;
            end
            default: ;
          endcase
          req_o.wdata = cmd_if.value;
        end
      end
      S_SHIFT: begin
        if (rd_pend_q) begin
          req_o.we = 1'b1;
          slot_in = slot_f(front_q, idx_q);
          req_o.wdata = rdata_i;
        end
        if (idx_q > stop_q && !rd_pend_q) begin
          req_o.re = 1'b1;
          log_rd = idx_q - 1'b1;
          slot_rd = slot_f(front_q, log_rd);
        end else if (idx_q == stop_q && !rd_pend_q) begin
          req_o.we = 1'b1;
          slot_in = slot_f(front_q, idx_q);
          req_o.wdata = val_q;
        end
      end
      S_SEARCH: begin
        if (rdata_i != val_q && idx_q + 1'b1 < count_q) begin
          req_o.re = 1'b1;
          slot_rd = slot_f(front_q, idx_q + 1'b1);
        end else if (rdata_i == val_q && idx_q + 1'b1 < count_q) begin
          req_o.re = 1'b1;
          slot_rd = slot_f(front_q, idx_q + 1'b1);
        end
      end
      S_DROP: begin
        if (rd_pend_q) begin
          req_o.we = 1'b1;
          slot_in = slot_f(front_q, idx_q);
          req_o.wdata = rdata_i;
        end else if (idx_q + 1'b1 < count_q) begin
          req_o.re = 1'b1;
          slot_rd = slot_f(front_q, idx_q + 1'b1);
        end
      end
      default: ;
    endcase
    req_o.waddr = (PosW+3)'(slot_in);
    req_o.raddr = (PosW+3)'(slot_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      idx_q <= '0;
      stop_q <= '0;
      val_q <= '0;
      st_q <= '0;
      data_q <= '0;
      occ_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_if.valid) begin
            val_q <= cmd_if.value;
            st_q <= ST_OK;
            data_q <= '0;
            occ_q <= count_q;
            state_q <= S_RESP;
            case (cmd_if.cmd)
              CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (count_q >= OccW'(DEPTH)) begin
                  st_q <= ST_FULL;
                end else begin
                  if (cmd_if.cmd == CMD_PUSH_FRONT) begin
                    front_q <= slot_f(front_q, OccW'(DEPTH - 1));
                  end
                  count_q <= count_q + 1'b1;
                  occ_q <= count_q + 1'b1;
                end
              end
              CMD_POP_FRONT, CMD_POP_BACK, CMD_READ_AT: begin
                if (cmd_if.cmd == CMD_READ_AT ? (pos_ext >= cnt_ext)
                                              : (count_q == '0)) begin
                  st_q <= (cmd_if.cmd == CMD_READ_AT) ? ST_BADIDX : ST_EMPTY;
                end else begin
                  state_q <= S_RDWAIT;
                  if (cmd_if.cmd == CMD_POP_FRONT) begin
                    front_q <= slot_f(front_q, OccW'(1));
                  end
                  if (cmd_if.cmd != CMD_READ_AT) begin
                    count_q <= count_q - 1'b1;
                    occ_q <= count_q - 1'b1;
                  end
                end
              end
              CMD_INSERT_AT: begin
                if (count_q >= OccW'(DEPTH)) begin
                  st_q <= ST_FULL;
                end else if (cmd_if.position == '0) begin
                  state_q <= S_SHIFT;
                  idx_q <= '0;
                  stop_q <= '0;
                  rd_pend_q <= 1'b0;
                  front_q <= slot_f(front_q, OccW'(DEPTH - 1));
                end else if (count_q == '0 ||
                             (count_q == OccW'(1) && cmd_if.position != 8'd1)) begin
                  st_q <= ST_BADIDX;
                end else begin
                  state_q <= S_SHIFT;
                  idx_q <= count_q;
                  rd_pend_q <= 1'b0;
                  stop_q <= (pos_ext >= cnt_ext) ? count_q : OccW'(cmd_if.position);
                end
              end
              CMD_DELETE: begin
                if (count_q == '0) begin
                  st_q <= ST_EMPTY;
                end else begin
                  state_q <= S_SEARCH;
                  idx_q <= '0;
                end
              end
              default: begin
                count_q <= '0;
                front_q <= '0;
                occ_q <= '0;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          data_q <= rdata_i;
          state_q <= S_RESP;
        end
        S_SHIFT: begin
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
            idx_q <= idx_q - 1'b1;
          end else if (idx_q > stop_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            count_q <= count_q + 1'b1;
            occ_q <= count_q + 1'b1;
            state_q <= S_RESP;
          end
        end
        S_SEARCH: begin
          if (rdata_i == val_q) begin
            data_q <= val_q;
            if (idx_q + 1'b1 < count_q) begin
              state_q <= S_DROP;
              rd_pend_q <= 1'b1;
            end else begin
              count_q <= count_q - 1'b1;
              occ_q <= count_q - 1'b1;
              state_q <= S_RESP;
            end
          end else if (idx_q + 1'b1 < count_q) begin
            idx_q <= idx_q + 1'b1;
          end else begin
            st_q <= ST_NOTFOUND;
            state_q <= S_RESP;
          end
        end
        S_DROP: begin
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
            idx_q <= idx_q + 1'b1;
          end else if (idx_q + 1'b1 < count_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            count_q <= count_q - 1'b1;
            occ_q <= count_q - 1'b1;
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp_if.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/bounded_deque_engine.sv
// bounded double-ended queue of signed 32-bit words
// cmd channel (valid/ready): cmd, value, position; rsp channel: status, data,
// occupancy, exactly one response per command, in order
// an item is taken only while the engine is idle, one command at a time
// push, clear and rejected commands go straight to the response register;
// pop and read_at pass through one synchronous memory read first
// insert_at moves the entries behind the index one at a time through the
// memory, a read then a write each; delete_value scans one entry per cycle
// then closes the gap by moving the entries behind the match one at a time
// throughput: the next command is taken the cycle after the response transfer
// reset clears the front pointer and the count; the store is not cleared,
// entry data is returned only after being written
// a stalled response holds the engine, no new command is taken until the
// response transfer completes
module bounded_deque_engine #(
  parameter int unsigned DEPTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  bde_cmd_if.sink   cmd_if,
  bde_rsp_if.source rsp_if
);
  import bde_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OccW = $clog2(DEPTH + 1);

  mem_req_t req;
  logic [DataW-1:0] rdata;

  bde_ctrl #(.DEPTH(DEPTH), .AW(AW), .OccW(OccW)) u_ctrl (
    .clk_i, .rst_ni, .cmd_if, .rsp_if, .req_o(req), .rdata_i(rdata)
  );

  bde_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i, .req_i(req), .rdata_o(rdata)
  );
endmodule

>>> hdl/bde_checker.sv
`include "bounded_deque_engine_macros.svh"
module bde_checker #(
  parameter int unsigned OccW = 5
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [2:0]      status,
  input logic [OccW-1:0] occ
);
  import bde_pkg::*;

  `BDE_ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid, !in_ready)
  `BDE_ASSERT_IMPL(a_status, clk_i, rst_ni, out_valid, status <= ST_NOTFOUND)
  `BDE_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(occ))
  `BDE_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid && in_ready, !in_ready)
endmodule

bind bounded_deque_engine bde_checker #(.OccW(OccW)) u_bde_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(cmd_if.valid), .in_ready(cmd_if.ready),
  .out_valid(rsp_if.valid), .out_ready(rsp_if.ready),
  .status(rsp_if.status), .occ(rsp_if.occupancy)
);
